@@ hw/rtl/ascii_hex_command_decoder_assert.svh @@
// Assertion macros used by the decoder's checker file.
`ifndef ASCII_HEX_COMMAND_DECODER_ASSERT_SVH
`define ASCII_HEX_COMMAND_DECODER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define AHCD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ahcd assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define AHCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ahcd assertion failed");

`endif

@@ hw/rtl/ahcd_pkg.sv @@
// Shared constants, types and decode functions of the ASCII hex command decoder.
`default_nettype none
package ahcd_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CMD_W  = 4;
	localparam int unsigned DIG_W  = 3;
	localparam int unsigned ARG_N  = 3;
	localparam int unsigned IDX_W  = 2;
	localparam int unsigned CFG_IDX_W = 2;

	// Decoder phases.
	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_DIGITS = 2'd1;
	localparam logic [1:0] PH_LF     = 2'd2;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_V = 4'd0;
	localparam logic [CMD_W-1:0] CMD_D = 4'd1;
	localparam logic [CMD_W-1:0] CMD_T = 4'd2;
	localparam logic [CMD_W-1:0] CMD_G = 4'd3;
	localparam logic [CMD_W-1:0] CMD_S = 4'd4;
	localparam logic [CMD_W-1:0] CMD_R = 4'd5;
	localparam logic [CMD_W-1:0] CMD_WR = 4'd6;
	localparam logic [CMD_W-1:0] CMD_Y = 4'd7;
	localparam logic [CMD_W-1:0] CMD_H = 4'd8;
	localparam logic [CMD_W-1:0] CMD_B = 4'd9;
	localparam logic [CMD_W-1:0] CMD_M = 4'd10;
	localparam logic [CMD_W-1:0] CMD_A = 4'd11;
	localparam logic [CMD_W-1:0] CMD_L = 4'd12;
	localparam logic [CMD_W-1:0] CMD_COUNT = 4'd13;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_MIN    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_MAX    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CONFIG_SIZE = 2'd2;

	localparam logic [BYTE_W-1:0] TEMP_MIN_RST    = 8'd10;
	localparam logic [BYTE_W-1:0] TEMP_MAX_RST    = 8'd60;
	localparam logic [BYTE_W-1:0] CONFIG_SIZE_RST = 8'd255;

	// Characters.
	localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;
	localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
	localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;
	localparam logic [BYTE_W-1:0] CH_LOW_A  = 8'h61;
	localparam logic [BYTE_W-1:0] CH_LOW_F  = 8'h66;

	// Password bytes of the B command.
	localparam logic [BYTE_W-1:0] PASS_HI = 8'h13;
	localparam logic [BYTE_W-1:0] PASS_LO = 8'h24;

	// Largest argument value that L accepts.
	localparam logic [BYTE_W-1:0] L_MAX = 8'd1;

	typedef struct packed {
		logic             hit;
		logic [CMD_W-1:0] code;
	} letter_t;

	function automatic letter_t letter_decode(input logic [BYTE_W-1:0] b);
		letter_t r;
		r.hit  = 1'b1;
		r.code = CMD_V;
		case (b)
			"V": r.code = CMD_V;
			"D": r.code = CMD_D;
			"T": r.code = CMD_T;
			"G": r.code = CMD_G;
			"S": r.code = CMD_S;
			"R": r.code = CMD_R;
			"W": r.code = CMD_WR;
			"Y": r.code = CMD_Y;
			"H": r.code = CMD_H;
			"B": r.code = CMD_B;
			"M": r.code = CMD_M;
			"A": r.code = CMD_A;
			"L": r.code = CMD_L;
			default: r.hit = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic [DIG_W-1:0] need_digits(input logic [CMD_W-1:0] cmd);
		logic [DIG_W-1:0] n;
		case (cmd)
			CMD_V, CMD_D:                n = 3'd0;
			CMD_S, CMD_B:                n = 3'd4;
			CMD_R, CMD_WR, CMD_Y, CMD_H: n = 3'd6;
			default:                     n = 3'd2;
		endcase
		return n;
	endfunction

endpackage
`default_nettype wire

@@ hw/rtl/ascii_hex_command_decoder.sv @@
// The byte that ends a command passes the input register before the result register loads its result.
// The decoder takes one byte per cycle, through the input register and the result register.
// A full result register that is not being read holds the input stage.
// Reset (arst_n low, asynchronous) empties both registers, returns the decoder to idle
// with cleared arguments and loads the register defaults.
`default_nettype none
module ascii_hex_command_decoder (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic [ahcd_pkg::BYTE_W-1:0]           rx_byte,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic [ahcd_pkg::CMD_W-1:0]                 command,
	output logic [ahcd_pkg::BYTE_W-1:0]                arg_first,
	output logic [ahcd_pkg::BYTE_W-1:0]                arg_second,
	output logic [ahcd_pkg::BYTE_W-1:0]                arg_third,
	output logic                                       malformed,
	output logic                                       act,
	input  wire logic                                  cfg_we,
	input  wire logic [ahcd_pkg::CFG_IDX_W-1:0]        cfg_idx,
	input  wire logic [ahcd_pkg::BYTE_W-1:0]           cfg_wdata
);

	logic                          valid_s1;
	logic [ahcd_pkg::BYTE_W-1:0]   rx_byte_s1;

	logic [ahcd_pkg::BYTE_W-1:0]   temp_min_q, temp_max_q, config_size_q;

	logic [1:0]                    phase_q, phase_d;
	logic [ahcd_pkg::CMD_W-1:0]    cmd_q, cmd_d;
	logic [ahcd_pkg::DIG_W-1:0]    digits_q, digits_d;
	logic [ahcd_pkg::BYTE_W-1:0]   arg_q [ahcd_pkg::ARG_N];
	logic [ahcd_pkg::BYTE_W-1:0]   arg_d [ahcd_pkg::ARG_N];

	logic                          out_valid_q;
	logic [ahcd_pkg::CMD_W-1:0]    res_cmd_q;
	logic [ahcd_pkg::BYTE_W-1:0]   res_arg0_q, res_arg1_q, res_arg2_q;
	logic                          res_bad_q, res_act_q;

	logic                          adv, fire, emit, res_bad, check_ok;
	logic [ahcd_pkg::BYTE_W-1:0]   b;
	logic                          dig_ok;
	logic [3:0]                    dig_val;
	logic [ahcd_pkg::IDX_W-1:0]    idx;
	logic [ahcd_pkg::DIG_W-1:0]    digits_inc;
	ahcd_pkg::letter_t             letter;

	// The input stage moves whenever the result register is free or being emptied.
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || adv;
	assign fire     = valid_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_min_q    <= ahcd_pkg::TEMP_MIN_RST;
			temp_max_q    <= ahcd_pkg::TEMP_MAX_RST;
			config_size_q <= ahcd_pkg::CONFIG_SIZE_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				ahcd_pkg::REG_TEMP_MIN:    temp_min_q    <= cfg_wdata;
				ahcd_pkg::REG_TEMP_MAX:    temp_max_q    <= cfg_wdata;
				ahcd_pkg::REG_CONFIG_SIZE: config_size_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		b = (rx_byte_s1 == ahcd_pkg::CH_CR) ? ahcd_pkg::CH_LF : rx_byte_s1;
		letter = ahcd_pkg::letter_decode(b);

		dig_ok  = 1'b0;
		dig_val = b[3:0];
		if (b >= ahcd_pkg::CH_ZERO && b <= ahcd_pkg::CH_NINE) begin
			dig_ok = 1'b1;
		end else if (b >= ahcd_pkg::CH_LOW_A && b <= ahcd_pkg::CH_LOW_F) begin
			dig_ok  = 1'b1;
			dig_val = b[3:0] + 4'd9;
		end

		// Argument byte index; the top code cannot occur but folds onto the last byte.
		idx = (digits_q[2:1] == 2'd3) ? 2'd2 : digits_q[2:1];
		digits_inc = digits_q + 3'd1;

		case (cmd_q)
			ahcd_pkg::CMD_S: check_ok = arg_q[0] < config_size_q;
			ahcd_pkg::CMD_B: check_ok = (arg_q[0] == ahcd_pkg::PASS_HI) &&
			                            (arg_q[1] == ahcd_pkg::PASS_LO);
			ahcd_pkg::CMD_A: check_ok = ({1'b0, arg_q[0]} + 9'd1 >= {1'b0, temp_min_q}) &&
			                            ({1'b0, arg_q[0]} <= {1'b0, temp_max_q} + 9'd1);
			ahcd_pkg::CMD_L: check_ok = arg_q[0] <= ahcd_pkg::L_MAX;
			default:         check_ok = 1'b1;
		endcase

		phase_d  = phase_q;
		cmd_d    = cmd_q;
		digits_d = digits_q;
		for (int i = 0; i < ahcd_pkg::ARG_N; i++) begin
			arg_d[i] = arg_q[i];
		end
		emit    = 1'b0;
		res_bad = 1'b0;

		if (fire && b != ahcd_pkg::CH_NUL) begin
			case (phase_q)
				ahcd_pkg::PH_DIGITS: begin
					if (!dig_ok) begin
						emit    = 1'b1;
						res_bad = 1'b1;
						phase_d = ahcd_pkg::PH_IDLE;
					end else begin
						if (digits_q[0]) begin
							arg_d[idx] = arg_q[idx] + {4'b0, dig_val};
						end else begin
							arg_d[idx] = {dig_val, 4'b0};
						end
						digits_d = digits_inc;
						if (cmd_q >= ahcd_pkg::CMD_COUNT ||
						    digits_inc >= ahcd_pkg::need_digits(cmd_q)) begin
							phase_d = ahcd_pkg::PH_LF;
						end
					end
				end
				ahcd_pkg::PH_LF: begin
					emit    = 1'b1;
					res_bad = (b != ahcd_pkg::CH_LF);
					phase_d = ahcd_pkg::PH_IDLE;
				end
				default: begin
					// Idle, and the unused phase code behaves the same.
					if (letter.hit) begin
						cmd_d    = letter.code;
						digits_d = '0;
						for (int i = 0; i < ahcd_pkg::ARG_N; i++) begin
							arg_d[i] = '0;
						end
						phase_d = (ahcd_pkg::need_digits(letter.code) == 3'd0) ?
						          ahcd_pkg::PH_LF : ahcd_pkg::PH_DIGITS;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= ahcd_pkg::PH_IDLE;
			cmd_q    <= ahcd_pkg::CMD_V;
			digits_q <= '0;
			for (int i = 0; i < ahcd_pkg::ARG_N; i++) begin
				arg_q[i] <= '0;
			end
		end else if (fire) begin
			phase_q  <= phase_d;
			cmd_q    <= cmd_d;
			digits_q <= digits_d;
			for (int i = 0; i < ahcd_pkg::ARG_N; i++) begin
				arg_q[i] <= arg_d[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_cmd_q  <= cmd_q;
			res_arg0_q <= arg_q[0];
			res_arg1_q <= arg_q[1];
			res_arg2_q <= arg_q[2];
			res_bad_q  <= res_bad;
			res_act_q  <= !res_bad && check_ok;
		end
	end

	assign out_valid  = out_valid_q;
	assign command    = res_cmd_q;
	assign arg_first  = res_arg0_q;
	assign arg_second = res_arg1_q;
	assign arg_third  = res_arg2_q;
	assign malformed  = res_bad_q;
	assign act        = res_act_q;

endmodule
`default_nettype wire

@@ hw/rtl/ahcd_checker.sv @@
// Port-level checks of the ASCII hex command decoder, bound to the top level.
`default_nettype none
`include "ascii_hex_command_decoder_assert.svh"
module ahcd_checker (
	input wire logic                                  clk,
	input wire logic                                  arst_n,
	input wire logic                                  out_valid,
	input wire logic                                  out_ready,
	input wire logic [ahcd_pkg::CMD_W-1:0]            command,
	input wire logic [ahcd_pkg::BYTE_W-1:0]           arg_first,
	input wire logic [ahcd_pkg::BYTE_W-1:0]           arg_second,
	input wire logic [ahcd_pkg::BYTE_W-1:0]           arg_third,
	input wire logic                                  malformed,
	input wire logic                                  act
);

	logic no_arg_cmd;

	assign no_arg_cmd = (command == ahcd_pkg::CMD_V) || (command == ahcd_pkg::CMD_D);

	// A stalled beat keeps its payload.
	`AHCD_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(command) && $stable(arg_first) && $stable(arg_second) && $stable(arg_third) && $stable(malformed) && $stable(act))

	// A malformed command is never acted on.
	`AHCD_ASSERT_NOW(a_bad_no_act, clk, arst_n, out_valid && malformed, !act)

	// Commands without digits carry cleared argument bytes.
	`AHCD_ASSERT_NOW(a_no_args, clk, arst_n, out_valid && no_arg_cmd, arg_first == '0 && arg_second == '0 && arg_third == '0)

	// L is acted on only for a value of zero or one.
	`AHCD_ASSERT_NOW(a_l_range, clk, arst_n, out_valid && act && command == ahcd_pkg::CMD_L, arg_first <= ahcd_pkg::L_MAX)

endmodule

bind ascii_hex_command_decoder ahcd_checker u_ahcd_checker (.*);
`default_nettype wire
